// ===== src/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms. Each use expects i_clk and i_rst_n to be
// visible in the module that expands it.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

// ===== src/ynrx_pkg.sv =====
// ============================================================================
// ynrx_pkg
// Types and constants shared by the stream decoder controller and datapath.
// ============================================================================
package ynrx_pkg;

    // Character codes of the yEnc line format.
    localparam logic [7:0] ChrCr  = 8'h0D;
    localparam logic [7:0] ChrLf  = 8'h0A;
    localparam logic [7:0] ChrEsc = 8'h3D;

    // Offsets of the yEnc and nibble coding.
    localparam logic [7:0] YencOffset = 8'd42;
    localparam logic [7:0] EscOffset  = 8'd64;
    localparam logic [7:0] HiMark     = 8'h40;
    localparam logic [7:0] LoMark     = 8'h50;
    localparam logic [3:0] NibMask    = 4'hF;

    // Number of byte lanes in one output word.
    localparam int MaxChunk = 8;

    // End-of-stream status codes.
    localparam logic [1:0] StatusOk     = 2'd0;
    localparam logic [1:0] StatusEsc    = 2'd1;
    localparam logic [1:0] StatusOddRle = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_busy;
        logic out_free;
        logic chunk_final;
    } t_dp_sts;

endpackage

// ===== src/ynrx_if.sv =====
// ============================================================================
// ynrx_if
// Valid/ready channels of the stream decoder: encoded input words and
// decoded output words.
// ============================================================================

// Input channel: one encoded byte per word.
interface ynrx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] enc_byte;
    logic       end_of_input;

    modport source (output valid, output enc_byte, output end_of_input, input ready);
    modport sink   (input valid, input enc_byte, input end_of_input, output ready);
endinterface

// Output channel: one chunk of up to eight decoded bytes per word.
interface ynrx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_b0;
    logic [7:0] out_b1;
    logic [7:0] out_b2;
    logic [7:0] out_b3;
    logic [7:0] out_b4;
    logic [7:0] out_b5;
    logic [7:0] out_b6;
    logic [7:0] out_b7;
    logic [3:0] byte_count;
    logic       last_chunk;
    logic [1:0] status;

    modport source (output valid, output out_b0, output out_b1, output out_b2,
                    output out_b3, output out_b4, output out_b5, output out_b6,
                    output out_b7, output byte_count, output last_chunk,
                    output status, input ready);
    modport sink   (input valid, input out_b0, input out_b1, input out_b2,
                    input out_b3, input out_b4, input out_b5, input out_b6,
                    input out_b7, input byte_count, input last_chunk,
                    input status, output ready);
endinterface

// ===== src/ynrx_ctrl.sv =====
// ============================================================================
// ynrx_ctrl
// Controller of the stream decoder: takes one input word at a time and
// sequences the chunk emission of a run before taking the next word.
// ============================================================================
module ynrx_ctrl import ynrx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_sts   i_sts,
    output t_ctrl_cmd o_cmd
);

    localparam logic StIdle = 1'b0;
    localparam logic StRun  = 1'b1;

    logic r_state;
    logic n_state;

    // Input is taken only between runs.
    assign o_in_ready = (r_state == StIdle);
    assign o_cmd.load = i_in_valid && (r_state == StIdle);
    assign o_cmd.emit = (r_state == StRun) && i_sts.out_free;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            StIdle: begin
                if (o_cmd.load && i_sts.item_busy) begin
                    n_state = StRun;
                end
            end
            StRun: begin
                if (o_cmd.emit && i_sts.chunk_final) begin
                    n_state = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/ynrx_dp.sv =====
// ============================================================================
// ynrx_dp
// Datapath of the stream decoder: yEnc and nibble decoding of each input
// byte, run-length state, the rolling XOR key and the output word register.
// ============================================================================
`include "assert_macros.svh"

module ynrx_dp import ynrx_pkg::*; #(
    parameter int CHUNK_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic [7:0] i_enc_byte,
    input  logic       i_end_of_input,
    input  logic       i_out_ready,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_sts    o_sts,
    output logic       o_out_valid,
    output logic [7:0] o_out_b [MaxChunk],
    output logic [3:0] o_byte_count,
    output logic       o_last_chunk,
    output logic [1:0] o_status
);

    localparam logic [7:0] ChunkLen8 = 8'(CHUNK_BYTES);
    localparam logic [3:0] ChunkLen4 = 4'(CHUNK_BYTES);

    // Stream state.
    logic       r_esc;
    logic       r_nph;
    logic [3:0] r_high;
    logic       r_rph;
    logic [7:0] r_run;
    logic [7:0] r_key;
    logic [7:0] r_init;

    // Run in progress.
    logic [7:0] r_rem;
    logic [7:0] r_val;
    logic       r_end;
    logic [1:0] r_stat;

    // Output word register.
    logic       r_out_valid;
    logic [7:0] r_out_b [MaxChunk];
    logic [3:0] r_out_cnt;
    logic       r_out_last;
    logic [1:0] r_out_stat;

    // Decode results for the byte on the input.
    logic       n_esc;
    logic       n_nph;
    logic [3:0] n_high;
    logic       n_rph;
    logic [7:0] n_run;
    logic       have;
    logic [7:0] dec;
    logic [7:0] hi_diff;
    logic [7:0] lo_diff;
    logic       pair;
    logic [7:0] pair_byte;
    logic       run_go;
    logic [1:0] item_stat;

    // Chunk forming.
    logic [3:0] chunk_cnt;
    logic       chunk_final;
    logic [7:0] chunk_b [MaxChunk];

    // yEnc, nibble and run-length decoding of one input byte.
    always_comb begin
        n_esc  = r_esc;
        have   = 1'b0;
        dec    = 8'd0;
        if (r_esc) begin
            n_esc = 1'b0;
            dec   = i_enc_byte - YencOffset - EscOffset;
            have  = 1'b1;
        end else if (i_enc_byte == ChrCr || i_enc_byte == ChrLf) begin
            have = 1'b0;
        end else if (i_enc_byte == ChrEsc) begin
            n_esc = 1'b1;
        end else begin
            dec  = i_enc_byte - YencOffset;
            have = 1'b1;
        end

        hi_diff   = dec - HiMark;
        lo_diff   = dec - LoMark;
        pair_byte = {r_high, lo_diff[3:0] & NibMask};
        n_nph     = r_nph;
        n_high    = r_high;
        pair      = 1'b0;
        if (have) begin
            if (!r_nph) begin
                n_high = hi_diff[3:0] & NibMask;
                n_nph  = 1'b1;
            end else begin
                pair  = 1'b1;
                n_nph = 1'b0;
            end
        end

        n_rph  = r_rph;
        n_run  = r_run;
        run_go = 1'b0;
        if (pair) begin
            if (!r_rph) begin
                n_run = pair_byte;
                n_rph = 1'b1;
            end else begin
                run_go = 1'b1;
                n_rph  = 1'b0;
            end
        end

        // A dangling escape wins over an unpaired count byte.
        item_stat = StatusOk;
        if (i_end_of_input) begin
            if (n_esc) begin
                item_stat = StatusEsc;
            end else if (n_rph) begin
                item_stat = StatusOddRle;
            end
        end
    end

    // Size of the next chunk and its bytes under the rolling key.
    assign chunk_final = (r_rem <= ChunkLen8);
    assign chunk_cnt   = chunk_final ? r_rem[3:0] : ChunkLen4;

    always_comb begin
        for (int j = 0; j < MaxChunk; j++) begin
            if (j < CHUNK_BYTES && 4'(j) < chunk_cnt) begin
                chunk_b[j] = r_val ^ (r_key + 8'(j));
            end else begin
                chunk_b[j] = 8'd0;
            end
        end
    end

    // Status to the controller.
    assign o_sts.item_busy   = (run_go && r_run != 8'd0) || i_end_of_input;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.chunk_final = chunk_final;

    // Stream state and run registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= 1'b0;
            r_nph  <= 1'b0;
            r_high <= 4'd0;
            r_rph  <= 1'b0;
            r_run  <= 8'd0;
            r_key  <= 8'd0;
            r_init <= 8'd0;
            r_rem  <= 8'd0;
            r_end  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_wdata;
                r_key  <= i_cfg_wdata;
            end else if (i_cmd.emit) begin
                r_rem <= r_rem - {4'd0, chunk_cnt};
                if (chunk_final && r_end) begin
                    r_key <= r_init;
                end else begin
                    r_key <= r_key + {4'd0, chunk_cnt};
                end
            end
            if (i_cmd.load) begin
                r_rem  <= run_go ? r_run : 8'd0;
                r_end  <= i_end_of_input;
                if (i_end_of_input) begin
                    r_esc  <= 1'b0;
                    r_nph  <= 1'b0;
                    r_high <= 4'd0;
                    r_rph  <= 1'b0;
                    r_run  <= 8'd0;
                end else begin
                    r_esc  <= n_esc;
                    r_nph  <= n_nph;
                    r_high <= n_high;
                    r_rph  <= n_rph;
                    r_run  <= n_run;
                end
            end
        end
    end

    // Run payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= pair_byte;
            r_stat <= item_stat;
        end
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_b    <= chunk_b;
            r_out_cnt  <= chunk_cnt;
            r_out_last <= chunk_final && r_end;
            r_out_stat <= (chunk_final && r_end) ? r_stat : StatusOk;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_b      = r_out_b;
    assign o_byte_count = r_out_cnt;
    assign o_last_chunk = r_out_last;
    assign o_status     = r_out_stat;

    // A word never holds more bytes than a chunk.
    `ASSERT_IMPLIES(a_cnt_bound, r_out_valid, r_out_cnt <= ChunkLen4)
    // A nonzero status travels only on the last word of a stream.
    `ASSERT_IMPLIES(a_stat_last, r_out_valid && r_out_stat != StatusOk, r_out_last)
    // Only the last word of a stream may be empty.
    `ASSERT_IMPLIES(a_empty_last, r_out_valid && r_out_cnt == 4'd0, r_out_last)
    // The key reloads once the final chunk of a stream is formed.
    `ASSERT_NEXT(a_key_reload, i_cmd.emit && chunk_final && r_end && !i_cfg_we,
                 r_key == r_init)

endmodule

// ===== src/yenc_nibble_rle_xor_decoder_unit.sv =====
// ============================================================================
// yenc_nibble_rle_xor_decoder_unit
// Stream decoder: yEnc, nibble pairing, run-length expansion, rolling XOR.
// ============================================================================
// Each input word carries one yEnc-encoded byte. CR and LF are skipped, '='
// escapes the next byte, and decoded bytes are paired from nibble characters
// into count/value pairs that expand into runs XORed with a key that starts
// at the configured value and counts up by one per byte. An input word that
// neither completes a run of at least one byte nor ends the stream leaves
// input open. A word that completes a run of n bytes, or ends the stream,
// holds input off while max(1, ceil(n / CHUNK_BYTES)) words are emitted;
// the single chunk former emits one word per cycle while the output register
// can take it. Output words pass through a register, so a stalled consumer
// delays chunk emission and with it the next input word. The key register
// may be written only while the block is idle; a write also restarts the key.
// ============================================================================
module yenc_nibble_rle_xor_decoder_unit import ynrx_pkg::*; #(
    parameter int CHUNK_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    ynrx_in_if.sink    i_in,
    ynrx_out_if.source o_out
);

    t_ctrl_cmd  cmd;
    t_dp_sts    sts;
    logic [7:0] out_b [MaxChunk];

    // Controller.
    ynrx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    ynrx_dp #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_enc_byte     (i_in.enc_byte),
        .i_end_of_input (i_in.end_of_input),
        .i_out_ready    (o_out.ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out.valid),
        .o_out_b        (out_b),
        .o_byte_count   (o_out.byte_count),
        .o_last_chunk   (o_out.last_chunk),
        .o_status       (o_out.status)
    );

    // Byte lanes onto the output channel.
    assign o_out.out_b0 = out_b[0];
    assign o_out.out_b1 = out_b[1];
    assign o_out.out_b2 = out_b[2];
    assign o_out.out_b3 = out_b[3];
    assign o_out.out_b4 = out_b[4];
    assign o_out.out_b5 = out_b[5];
    assign o_out.out_b6 = out_b[6];
    assign o_out.out_b7 = out_b[7];

endmodule

// ===== dv/ynrx_decode_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ynrx_decode_checker
// Passive checker for the stream decoder. It watches the key register port
// and both channels, predicts the decoded words of every accepted input word
// and compares each accepted output word field by field, in order.
// ============================================================================
module ynrx_decode_checker import ynrx_pkg::*; #(
    parameter int CHUNK_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    ynrx_in_if         i_enc,
    ynrx_out_if        i_dec,
    output int         o_fail_count,
    output int         o_pending
);

    // One decoded output word as the block should present it.
    typedef struct packed {
        logic [7:0][7:0] data;
        logic [3:0]      count;
        logic            last;
        logic [1:0]      status;
    } chunk_t;

    chunk_t expected_chunks[$];

    // Decoder state, mirrored from the block's documented behavior.
    logic [7:0] key_init;
    logic [7:0] key_now;
    logic       esc_pending;
    logic       nib_second;
    logic [3:0] hi_nib;
    logic       rle_value_next;
    logic [7:0] run_len;

    int fails;
    int words_seen;

    // Every stream begins from this state; the key reloads from the register.
    task automatic restart_stream();
        esc_pending    = 1'b0;
        nib_second     = 1'b0;
        hi_nib         = 4'h0;
        rle_value_next = 1'b0;
        run_len        = 8'h00;
        key_now        = key_init;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] decoded word %0d: %s", $time, words_seen, msg);
        fails++;
    endtask

    // Run one encoded byte through the four stages and queue the words it makes.
    task automatic decode_word(input logic [7:0] c, input logic eoi);
        logic [7:0] d;
        logic [7:0] tmp;
        logic       have;
        logic [1:0] st;
        logic [7:0] run_bytes[$];
        chunk_t     ch;
        int         nchunks;
        int         pos;
        int         take;

        have = 1'b0;
        d    = 8'h00;

        // yEnc: the byte after an escape is always data, even CR, LF or '='.
        if (esc_pending) begin
            esc_pending = 1'b0;
            d = c - YencOffset - EscOffset;
            have = 1'b1;
        end else if (c == ChrCr || c == ChrLf) begin
            have = 1'b0;
        end else if (c == ChrEsc) begin
            esc_pending = 1'b1;
        end else begin
            d = c - YencOffset;
            have = 1'b1;
        end

        // Nibble pairing: the first character only holds the high nibble.
        if (have) begin
            if (!nib_second) begin
                tmp = d - HiMark;
                hi_nib = tmp[3:0] & NibMask;
                nib_second = 1'b1;
                have = 1'b0;
            end else begin
                tmp = d - LoMark;
                d = {hi_nib, tmp[3:0] & NibMask};
                nib_second = 1'b0;
            end
        end

        // Run-length expansion with the rolling key applied per byte.
        if (have) begin
            if (!rle_value_next) begin
                run_len = d;
                rle_value_next = 1'b1;
            end else begin
                for (int i = 0; i < run_len; i++) begin
                    run_bytes.push_back(d ^ key_now);
                    key_now = key_now + 8'd1;
                end
                rle_value_next = 1'b0;
            end
        end

        // A dangling escape wins over a missing run value.
        st = StatusOk;
        if (eoi) begin
            if (esc_pending) begin
                st = StatusEsc;
            end else if (rle_value_next) begin
                st = StatusOddRle;
            end
        end

        // Split into words; the end of a stream always yields at least one.
        nchunks = (run_bytes.size() + CHUNK_BYTES - 1) / CHUNK_BYTES;
        if (eoi && nchunks == 0) begin
            nchunks = 1;
        end
        pos = 0;
        for (int r = 0; r < nchunks; r++) begin
            ch = '0;
            take = run_bytes.size() - pos;
            if (take > CHUNK_BYTES) begin
                take = CHUNK_BYTES;
            end
            for (int j = 0; j < take; j++) begin
                ch.data[j] = run_bytes[pos + j];
            end
            pos += take;
            ch.count = 4'(take);
            if (eoi && r == nchunks - 1) begin
                ch.last = 1'b1;
                ch.status = st;
            end
            expected_chunks.push_back(ch);
        end

        if (eoi) begin
            restart_stream();
        end
    endtask

    // Compare one accepted output word with the oldest prediction.
    task automatic check_chunk();
        chunk_t     want;
        logic [7:0] lanes [8];

        lanes = '{i_dec.out_b0, i_dec.out_b1, i_dec.out_b2, i_dec.out_b3,
                  i_dec.out_b4, i_dec.out_b5, i_dec.out_b6, i_dec.out_b7};
        if (expected_chunks.size() == 0) begin
            report_mismatch($sformatf("unexpected word, byte_count %0d last_chunk %0b",
                                      i_dec.byte_count, i_dec.last_chunk));
        end else begin
            want = expected_chunks.pop_front();
            for (int j = 0; j < 8; j++) begin
                if (lanes[j] !== want.data[j]) begin
                    report_mismatch($sformatf("out_b%0d expected %02h, got %02h",
                                              j, want.data[j], lanes[j]));
                end
            end
            if (i_dec.byte_count !== want.count) begin
                report_mismatch($sformatf("byte_count expected %0d, got %0d",
                                          want.count, i_dec.byte_count));
            end
            if (i_dec.last_chunk !== want.last) begin
                report_mismatch($sformatf("last_chunk expected %0b, got %0b",
                                          want.last, i_dec.last_chunk));
            end
            if (i_dec.status !== want.status) begin
                report_mismatch($sformatf("status expected %0d, got %0d",
                                          want.status, i_dec.status));
            end
        end
        words_seen++;
    endtask

    // Key writes, then input acceptance, then output acceptance at each edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_init = 8'h00;
            restart_stream();
            expected_chunks.delete();
        end else begin
            if (i_cfg_we) begin
                key_init = i_cfg_wdata;
                key_now  = i_cfg_wdata;
            end
            if (i_enc.valid && i_enc.ready) begin
                decode_word(i_enc.enc_byte, i_enc.end_of_input);
            end
            if (i_dec.valid && i_dec.ready) begin
                check_chunk();
            end
        end
        o_pending    <= expected_chunks.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb_yenc_nibble_rle_xor_decoder_unit.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_yenc_nibble_rle_xor_decoder_unit
// Stimulus and verdict for the stream decoder. A directed pass covers escaped
// control characters, zero and maximum runs and every end-of-stream status;
// random phases under several key values then send well-formed streams with
// random content, noise and broken endings, with random idling on both sides
// and one long output stall. The checker beside the block does the compare.
// ============================================================================
module tb_yenc_nibble_rle_xor_decoder_unit;
    import ynrx_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 66;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
    } enc_word_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         fail_count;
    int         pending;
    int         cycle_count;
    int         hold_requests = 0;
    bit         calm = 1'b0;
    bit         noisy = 1'b0;

    enc_word_t  stream_words[$];

    ynrx_in_if  enc_ch();
    ynrx_out_if dec_ch();

    yenc_nibble_rle_xor_decoder_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (enc_ch),
        .o_out       (dec_ch)
    );

    ynrx_decode_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_enc        (enc_ch),
        .i_dec        (dec_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock.
    always begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    task automatic add_word(input logic [7:0] b);
        stream_words.push_back('{b: b, eoi: 1'b0});
    endtask

    // One nibble character; random upper bits, escape and line breaks when noisy.
    task automatic add_char(input logic [3:0] nib, input logic low_half);
        logic [7:0] d;
        logic [7:0] e;

        d = (low_half ? LoMark : HiMark) + {(noisy ? 4'($urandom) : 4'h0), nib};
        e = d + YencOffset;
        if (noisy && $urandom_range(0, 9) == 0) begin
            add_word($urandom_range(0, 1) ? ChrCr : ChrLf);
        end
        if (e == ChrCr || e == ChrLf || e == ChrEsc || (noisy && $urandom_range(0, 7) == 0))
        begin
            add_word(ChrEsc);
            add_word(d + YencOffset + EscOffset);
        end else begin
            add_word(e);
        end
    endtask

    task automatic add_byte(input logic [7:0] v);
        add_char(v[7:4], 1'b0);
        add_char(v[3:0], 1'b1);
    endtask

    task automatic end_stream();
        stream_words[stream_words.size() - 1].eoi = 1'b1;
    endtask

    // Offer one word and hold it until accepted, with an optional gap first.
    task automatic push_word(input enc_word_t w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            enc_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        enc_ch.valid        <= 1'b1;
        enc_ch.enc_byte     <= w.b;
        enc_ch.end_of_input <= w.eoi;
        @(posedge clk);
        while (!enc_ch.ready) @(posedge clk);
    endtask

    task automatic send_stream(inout int sent);
        foreach (stream_words[i]) begin
            push_word(stream_words[i]);
        end
        sent += stream_words.size();
        stream_words.delete();
    endtask

    // Let every predicted word arrive, then let the block settle.
    task automatic wait_idle();
        enc_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed count/value streams; some raw noise and broken endings.
    task automatic build_random_stream();
        int         pairs;
        logic [7:0] cnt;

        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(3, 12)) add_word(8'($urandom_range(0, 255)));
        end else begin
            pairs = $urandom_range(1, 6);
            repeat (pairs) begin
                if ($urandom_range(0, 99) < 5) begin
                    cnt = 8'($urandom_range(13, 255));
                end else begin
                    cnt = 8'($urandom_range(0, 12));
                end
                add_byte(cnt);
                add_byte(8'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 9))
                6: begin
                    add_word(ChrEsc);
                end
                7: begin
                    add_byte(8'($urandom_range(0, 255)));
                end
                8: begin
                    add_char(4'($urandom), 1'b0);
                end
                9: begin
                    add_word($urandom_range(0, 1) ? ChrCr : ChrLf);
                end
                default: begin
                end
            endcase
        end
        end_stream();
    endtask

    // Output side: random stalls, one long hold-off on request.
    initial begin
        int holds_done;

        holds_done = 0;
        dec_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (holds_done < hold_requests) begin
                holds_done++;
                dec_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                dec_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                dec_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence.
    initial begin
        int         sent;
        logic [7:0] phase_key;

        sent = 0;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= 8'h00;
        enc_ch.valid        <= 1'b0;
        enc_ch.enc_byte     <= 8'h00;
        enc_ch.end_of_input <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_key(8'hFF);

        // Zero run, then escaped CR and LF forming the count 0x30.
        add_byte(8'h00);
        add_byte(8'hAB);
        add_word(ChrEsc);
        add_word(ChrCr);
        add_word(ChrEsc);
        add_word(ChrLf);
        // Escaped '=', a skipped CR and a raw 0xFF form the value 0x35.
        add_word(ChrEsc);
        add_word(ChrEsc);
        add_word(ChrCr);
        add_word(8'hFF);
        // Longest run, then the stream ends on an escape with nothing after it.
        add_byte(8'hFF);
        add_byte(8'h00);
        add_word(ChrLf);
        add_word(ChrEsc);
        end_stream();
        send_stream(sent);

        // Count without value and a lone nibble, ended on a CR: no bytes out.
        add_byte(8'h01);
        add_char(4'h7, 1'b0);
        add_word(ChrCr);
        end_stream();
        send_stream(sent);

        // Short run ending the stream; a raw 0x00 supplies the high nibble.
        add_byte(8'h03);
        add_word(8'h00);
        add_char(4'hE, 1'b1);
        end_stream();
        send_stream(sent);
        wait_idle();

        // Random phases, each under its own key; the last one without idling.
        noisy = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: phase_key = 8'h00;
                2: phase_key = 8'hFF;
                default: phase_key = 8'($urandom_range(1, 254));
            endcase
            write_key(phase_key);
            if (phase == 3) begin
                calm = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_WORDS) begin
                build_random_stream();
                if (phase == 0 && hold_requests == 0 && sent > 20) begin
                    hold_requests = 1;
                end
                send_stream(sent);
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/ynrx_pkg.sv
src/ynrx_if.sv
src/ynrx_ctrl.sv
src/ynrx_dp.sv
src/yenc_nibble_rle_xor_decoder_unit.sv
dv/ynrx_decode_checker.sv
dv/tb_yenc_nibble_rle_xor_decoder_unit.sv
